[design/chunk_reassembly_tracker_unit_assert.svh]
// Assertion macros for the chunk reassembly tracker.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef CHUNK_REASSEMBLY_TRACKER_UNIT_ASSERT_SVH
`define CHUNK_REASSEMBLY_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CRT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crt assertion failed");

// Next-cycle implication, checked outside reset.
`define CRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crt assertion failed");

`endif

[design/crt_pkg.sv]
// Shared types and constants of the chunk reassembly tracker.
// No dependencies; used by the cell, the head unit and the top level.
`default_nettype none

package crt_pkg;

  localparam int MAX_CHUNKS  = 32;
  localparam int MAX_RESULTS = 16;
  localparam int CW          = $clog2(MAX_CHUNKS + 1);
  localparam int RESW        = $clog2(MAX_RESULTS + 1);
  localparam int IW          = 8;
  localparam int TOTW        = 6;
  localparam int FW          = 32;
  localparam int AW          = 16;
  localparam int EVW         = 3;
  localparam int NEEDW       = 6;
  localparam int CFGW        = 16;

  localparam logic [AW-1:0] AGE_MAX = '1;

  localparam logic CMD_CHUNK = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic CFG_NEED   = 1'b0;
  localparam logic CFG_WINDOW = 1'b1;

  localparam logic [EVW-1:0] EV_STORED    = 3'd0;
  localparam logic [EVW-1:0] EV_DUPLICATE = 3'd1;
  localparam logic [EVW-1:0] EV_RANGE     = 3'd2;
  localparam logic [EVW-1:0] EV_COMPLETE  = 3'd3;
  localparam logic [EVW-1:0] EV_EXPIRED   = 3'd4;
  localparam logic [EVW-1:0] EV_FULL      = 3'd5;

  localparam logic [NEEDW-1:0] NEED_RESET   = 6'd8;
  localparam logic [AW-1:0]    WINDOW_RESET = 16'd50;

  typedef struct packed {
    logic                  valid;
    logic                  mark;
    logic [FW-1:0]         frame;
    logic [CW-1:0]         total;
    logic [MAX_CHUNKS-1:0] bitmap;
    logic [CW-1:0]         count;
    logic [AW-1:0]         age;
  } slot_t;

  typedef struct packed {
    logic              cmd;
    logic [FW-1:0]     fid;
    logic [IW-1:0]     idx;
    logic [TOTW-1:0]   tot;
    logic              any_hit;
    logic              any_free;
    logic              alloc_done;
    logic              room;
    logic              first;
    logic [NEEDW-1:0]  need;
    logic [AW-1:0]     window;
  } head_ctl_t;

  typedef struct packed {
    logic           found;
    logic           alloc;
    logic [EVW-1:0] ev;
    logic [FW-1:0]  frame;
    logic [CW-1:0]  count;
  } head_res_t;

endpackage

`default_nettype wire

[design/crt_cell.sv]
// One slot of the tracker ring: holds a slot and takes its neighbor's slot on shift.
// Depends on crt_pkg.
`default_nettype none

module crt_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              shift,
  input  wire logic              load_mark,
  input  wire logic              mark_en,
  input  wire logic [crt_pkg::FW-1:0] fid,
  input  wire crt_pkg::slot_t    slot_in,
  output crt_pkg::slot_t         slot_out,
  output logic                   hit
);

  logic                           valid;
  logic                           mark;
  logic [crt_pkg::FW-1:0]         frame;
  logic [crt_pkg::CW-1:0]         total;
  logic [crt_pkg::MAX_CHUNKS-1:0] bitmap;
  logic [crt_pkg::CW-1:0]         count;
  logic [crt_pkg::AW-1:0]         age;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= slot_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      mark   <= slot_in.mark;
      frame  <= slot_in.frame;
      total  <= slot_in.total;
      bitmap <= slot_in.bitmap;
      count  <= slot_in.count;
      age    <= slot_in.age;
    end else if (load_mark) begin
      mark <= mark_en && hit;
    end
  end

  assign hit = valid && (frame == fid);

  assign slot_out = '{valid: valid, mark: mark, frame: frame, total: total,
                      bitmap: bitmap, count: count, age: age};

endmodule

`default_nettype wire

[design/crt_head.sv]
// Head unit of the ring: applies a chunk or a tick to the slot passing by.
// Depends on crt_pkg.
`default_nettype none

module crt_head (
  input  wire crt_pkg::head_ctl_t ctl,
  input  wire crt_pkg::slot_t     slot_in,
  output crt_pkg::slot_t          slot_out,
  output crt_pkg::head_res_t      res
);

  logic [crt_pkg::AW-1:0]         age_n;
  logic                           sel;
  logic                           is_new;
  logic [crt_pkg::CW-1:0]         tot_eff;
  logic [crt_pkg::MAX_CHUNKS-1:0] bm;
  logic [crt_pkg::CW-1:0]         cnt;
  logic [crt_pkg::CW-1:0]         cnt1;
  logic [crt_pkg::MAX_CHUNKS-1:0] onehot;
  logic                           in_range;
  logic                           bit_set;

  always_comb begin
    for (int b = 0; b < crt_pkg::MAX_CHUNKS; b++) begin
      onehot[b] = (ctl.idx == crt_pkg::IW'(b));
    end
  end

  always_comb begin
    slot_out      = slot_in;
    slot_out.mark = 1'b0;
    res           = '0;
    age_n         = (slot_in.age == crt_pkg::AGE_MAX) ? slot_in.age
                                                      : slot_in.age + 1'b1;
    is_new  = !ctl.any_hit;
    sel     = ctl.any_hit ? slot_in.mark : (!slot_in.valid && !ctl.alloc_done);
    if (crt_pkg::IW'(ctl.tot) > crt_pkg::IW'(crt_pkg::MAX_CHUNKS)) begin
      tot_eff = crt_pkg::CW'(crt_pkg::MAX_CHUNKS);
    end else begin
      tot_eff = crt_pkg::CW'(ctl.tot);
    end
    if (!is_new) begin
      tot_eff = slot_in.total;
    end
    bm       = is_new ? '0 : slot_in.bitmap;
    cnt      = is_new ? '0 : slot_in.count;
    cnt1     = cnt + 1'b1;
    in_range = ctl.idx < crt_pkg::IW'(tot_eff);
    bit_set  = |(bm & onehot);

    if (ctl.cmd == crt_pkg::CMD_TICK) begin
      if (slot_in.valid) begin
        slot_out.age = age_n;
        if (age_n > ctl.window && ctl.room) begin
          slot_out.valid = 1'b0;
          res.found = 1'b1;
          res.ev    = crt_pkg::EV_EXPIRED;
          res.frame = slot_in.frame;
          res.count = slot_in.count;
        end
      end
    end else if (!ctl.any_hit && !ctl.any_free) begin
      // Table full: report once, at the first slot, and change nothing.
      if (ctl.first) begin
        res.found = 1'b1;
        res.ev    = crt_pkg::EV_FULL;
        res.frame = ctl.fid;
        res.count = '0;
      end
    end else if (sel) begin
      res.found = 1'b1;
      res.alloc = is_new;
      res.frame = ctl.fid;
      if (is_new) begin
        slot_out.valid  = 1'b1;
        slot_out.frame  = ctl.fid;
        slot_out.total  = tot_eff;
        slot_out.bitmap = '0;
        slot_out.count  = '0;
        slot_out.age    = '0;
      end
      if (in_range && bit_set) begin
        res.ev    = crt_pkg::EV_DUPLICATE;
        res.count = cnt;
      end else if (!in_range) begin
        res.ev    = crt_pkg::EV_RANGE;
        res.count = cnt;
      end else begin
        slot_out.bitmap = bm | onehot;
        slot_out.count  = cnt1;
        res.count       = cnt1;
        if (8'(cnt1) >= 8'(ctl.need)) begin
          slot_out.valid = 1'b0;
          res.ev         = crt_pkg::EV_COMPLETE;
        end else begin
          res.ev = crt_pkg::EV_STORED;
        end
      end
    end
  end

endmodule

`default_nettype wire

[design/chunk_reassembly_tracker_unit.sv]
// Top level of the chunk reassembly tracker: ring of slot cells, head unit, control.
// Depends on crt_pkg, crt_cell, crt_head and the assertion macro header.
//
//  Channel   Handshake            Fields
//  command   start / busy         cmd, frame_key, chunk_index, chunk_total
//  result    result_strobe        event_res, event_frame, received_count, last
//  config    cfg_we, cfg_index    cfg_data
//
// Every item, chunk or tick, rotates the whole ring of ENTRIES slots once through
// the head unit, one slot per cycle, then flushes its last result; busy stays high
// through the sweep and the flush.
// The final result of an item is on the ports in the first cycle with busy low.
// Reset clears all slots to free and the config and control registers to their defaults.
// Results cannot be stalled; each is shown for exactly one cycle.
`default_nettype none

`include "chunk_reassembly_tracker_unit_assert.svh"

module chunk_reassembly_tracker_unit #(
  parameter int ENTRIES = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         cmd,
  input  wire logic [crt_pkg::FW-1:0]       frame_key,
  input  wire logic [crt_pkg::IW-1:0]       chunk_index,
  input  wire logic [crt_pkg::TOTW-1:0]     chunk_total,
  output logic                              result_strobe,
  output logic [crt_pkg::EVW-1:0]           event_res,
  output logic [crt_pkg::FW-1:0]            event_frame,
  output logic [5:0]                        received_count,
  output logic                              last,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [crt_pkg::CFGW-1:0]     cfg_data
);

  localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]                  state;
  logic [SW-1:0]               step;
  logic [crt_pkg::RESW-1:0]    n_res;
  logic                        accept;
  logic                        shift;

  logic [crt_pkg::NEEDW-1:0]   need_chunks;
  logic [crt_pkg::AW-1:0]      window_ticks;

  logic                        cmd_r;
  logic [crt_pkg::FW-1:0]      fid_r;
  logic [crt_pkg::IW-1:0]      idx_r;
  logic [crt_pkg::TOTW-1:0]    tot_r;
  logic                        any_hit;
  logic                        any_free;
  logic                        alloc_done;

  logic                        pend_v;
  logic [crt_pkg::EVW-1:0]     pend_ev;
  logic [crt_pkg::FW-1:0]      pend_frame;
  logic [crt_pkg::CW-1:0]      pend_count;

  crt_pkg::slot_t              cell_slot [ENTRIES];
  crt_pkg::slot_t              head_out;
  crt_pkg::head_ctl_t          ctl;
  crt_pkg::head_res_t          res;
  logic [ENTRIES-1:0]          hit_vec;
  logic [ENTRIES-1:0]          free_vec;
  logic [ENTRIES-1:0]          mark_vec;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign shift  = (state == ST_SWEEP);

  // Slot j rests in cell j; the ring shifts toward cell 0, which feeds the head.
  for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
    crt_pkg::slot_t nb;
    if (j == ENTRIES - 1) begin : g_tail
      assign nb = head_out;
    end else begin : g_mid
      assign nb = cell_slot[j+1];
    end
    crt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (shift),
      .load_mark (accept),
      .mark_en   (cmd == crt_pkg::CMD_CHUNK),
      .fid       (frame_key),
      .slot_in   (nb),
      .slot_out  (cell_slot[j]),
      .hit       (hit_vec[j])
    );
    assign free_vec[j] = !cell_slot[j].valid;
    assign mark_vec[j] = cell_slot[j].mark;
  end

  assign ctl = '{cmd: cmd_r, fid: fid_r, idx: idx_r, tot: tot_r,
                 any_hit: any_hit, any_free: any_free, alloc_done: alloc_done,
                 room: (n_res < crt_pkg::RESW'(crt_pkg::MAX_RESULTS)),
                 first: (step == '0), need: need_chunks, window: window_ticks};

  crt_head u_head (
    .ctl      (ctl),
    .slot_in  (cell_slot[0]),
    .slot_out (head_out),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      need_chunks  <= crt_pkg::NEED_RESET;
      window_ticks <= crt_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        crt_pkg::CFG_NEED:   need_chunks  <= cfg_data[crt_pkg::NEEDW-1:0];
        crt_pkg::CFG_WINDOW: window_ticks <= cfg_data[crt_pkg::AW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= cmd;
      fid_r    <= frame_key;
      idx_r    <= chunk_index;
      tot_r    <= chunk_total;
      any_hit  <= (cmd == crt_pkg::CMD_CHUNK) && (|hit_vec);
      any_free <= |free_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      n_res         <= '0;
      alloc_done    <= 1'b0;
      pend_v        <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          result_strobe <= 1'b0;
          if (start) begin
            state      <= ST_SWEEP;
            step       <= '0;
            n_res      <= '0;
            alloc_done <= 1'b0;
          end
        end
        ST_SWEEP: begin
          // A result is held until the next one, so the last of the item can be marked.
          result_strobe <= res.found && pend_v;
          if (res.found) begin
            if (pend_v) begin
              event_res      <= pend_ev;
              event_frame    <= pend_frame;
              received_count <= 6'(pend_count);
              last           <= 1'b0;
            end
            pend_v     <= 1'b1;
            pend_ev    <= res.ev;
            pend_frame <= res.frame;
            pend_count <= res.count;
            n_res      <= n_res + 1'b1;
          end
          if (res.alloc) begin
            alloc_done <= 1'b1;
          end
          if (step == SW'(ENTRIES - 1)) begin
            state <= ST_FLUSH;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_FLUSH: begin
          result_strobe <= pend_v;
          if (pend_v) begin
            event_res      <= pend_ev;
            event_frame    <= pend_frame;
            received_count <= 6'(pend_count);
            last           <= 1'b1;
            pend_v         <= 1'b0;
          end
          state <= ST_IDLE;
        end
        default: begin
          result_strobe <= 1'b0;
          state         <= ST_IDLE;
        end
      endcase
    end
  end

  `CRT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `CRT_ASSERT_NOW(a_last_idle, result_strobe && last, !busy)
  `CRT_ASSERT_NOW(a_more_busy, result_strobe && !last, busy)
  `CRT_ASSERT_NOW(a_idle_no_pend, state == ST_IDLE, !pend_v)
  `CRT_ASSERT_NOW(a_one_mark, state == ST_SWEEP, $onehot0(mark_vec))

endmodule

`default_nettype wire
